// ===== sv/lkvc_pkg.sv =====
// Shared types and constants for the LRU key-value cache.
package lkvc_pkg;

  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int CAP_W       = 5;
  localparam int CAP_RESET   = 16;
  localparam int ENTRIES_DEF = 16;

  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  // One stored entry as it moves from cell to cell.
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic go;
    logic is_put;
    logic hit;
    logic clr;
  } ctrl_t;

endpackage

// ===== sv/lkvc_cell.sv =====
// One cell of the recency-ordered entry row.
module lkvc_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lkvc_pkg::ctrl_t                   ctrl,
  input  logic [CNT_W-1:0]                  cap,
  input  logic [lkvc_pkg::KEY_W-1:0]        req_key,
  input  lkvc_pkg::entry_t                  ent_i,
  input  logic                              hb_i,
  output lkvc_pkg::entry_t                  ent_o,
  output logic                              hb_o,
  output logic                              match_o,
  output logic [lkvc_pkg::VAL_W-1:0]        val_o
);
  import lkvc_pkg::*;

  logic             vld_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;
  logic             in_cap;
  logic             load;

  assign in_cap  = 32'(IDX) < 32'(cap);
  assign match_o = vld_r && (key_r == req_key);
  assign hb_o    = hb_i | match_o;
  assign val_o   = match_o ? val_r : '0;
  assign ent_o   = '{valid: vld_r, key: key_r, value: val_r};

  // On a hit the cells from the head down to the hit shift by one; on an
  // insert every cell within the capacity shifts and the tail drops out.
  assign load = ctrl.go && (ctrl.hit ? !hb_i : (ctrl.is_put && in_cap));

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clr) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= ent_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      key_r <= ent_i.key;
      val_r <= ent_i.value;
    end
  end

endmodule

// ===== sv/lru_key_value_cache_core.sv =====
// Top level of the LRU key-value cache: request register, cell row and result register.
//
//   Channel   Direction  Handshake              Payload
//   in_       input      in_valid / in_stall    in_action, in_key, in_value
//   out_      output     out_valid / out_stall  out_hit, out_read_value
//   cfg_      input      cfg_valid / cfg_ready  cfg_capacity_in_use
//
// A request is registered on transfer and executed once the result register
// can take its result, so one request per cycle is sustained while the result
// side does not stall; a get result is then registered for output. The compare
// across the cell row, its hit prefix chain and the value OR tree is combinational.
// Reset clears every valid bit and loads the capacity of 16 (saturated to
// ENTRIES). A capacity write clears the store at the end of its transfer cycle.
// A stalled result holds the request register, which in turn stalls the input.
module lru_key_value_cache_core #(
  parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_action,
  input  logic signed [lkvc_pkg::KEY_W-1:0]      in_key,
  input  logic signed [lkvc_pkg::VAL_W-1:0]      in_value,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   out_hit,
  output logic signed [lkvc_pkg::VAL_W-1:0]      out_read_value,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [lkvc_pkg::CAP_W-1:0]             cfg_capacity_in_use
);
  import lkvc_pkg::*;

  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int CAP_RST = (CAP_RESET > ENTRIES) ? ENTRIES : CAP_RESET;

  // Request register.
  logic             req_vld_r, req_vld_nxt;
  logic             req_put_r;
  logic [KEY_W-1:0] req_key_r;
  logic [VAL_W-1:0] req_val_r;

  // Effective capacity, already clamped to 1 .. ENTRIES.
  logic [CNT_W-1:0] cap_r, cap_nxt;

  // Result register.
  logic             out_vld_r, out_vld_nxt;
  logic             out_hit_r;
  logic [VAL_W-1:0] out_val_r;

  logic             in_xfer;
  logic             cfg_xfer;
  logic             exec_go;
  ctrl_t            ctrl;
  logic             hit;
  logic [VAL_W-1:0] rd_val;
  entry_t           head_ent;

  entry_t           ent_chain [ENTRIES];
  logic             hb_chain  [ENTRIES];
  logic [ENTRIES-1:0] match_vec;
  logic [ENTRIES-1:0] vld_vec;
  logic [VAL_W-1:0] val_vec   [ENTRIES];

  // The request executes whenever the result register can take its result.
  assign exec_go   = req_vld_r && !(out_vld_r && out_stall);
  assign in_stall  = req_vld_r && !exec_go;
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = !req_vld_r;
  assign cfg_xfer  = cfg_valid && cfg_ready;

  assign hit = hb_chain[ENTRIES-1];

  // At most one cell matches, so an OR of the masked values selects it.
  always_comb begin
    rd_val = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      rd_val = rd_val | val_vec[i];
    end
  end

  assign ctrl = '{go: exec_go, is_put: req_put_r, hit: hit, clr: cfg_xfer};

  // The head cell always receives the touched or newly inserted entry.
  assign head_ent = '{valid: 1'b1, key: req_key_r,
                      value: (req_put_r ? req_val_r : rd_val)};

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lkvc_cell #(
      .IDX   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .cap     (cap_r),
      .req_key (req_key_r),
      .ent_i   ((g == 0) ? head_ent : ent_chain[(g == 0) ? 0 : g-1]),
      .hb_i    ((g == 0) ? 1'b0 : hb_chain[(g == 0) ? 0 : g-1]),
      .ent_o   (ent_chain[g]),
      .hb_o    (hb_chain[g]),
      .match_o (match_vec[g]),
      .val_o   (val_vec[g])
    );
    assign vld_vec[g] = ent_chain[g].valid;
  end

  always_comb begin
    req_vld_nxt = req_vld_r;
    if (in_xfer) begin
      req_vld_nxt = 1'b1;
    end else if (exec_go) begin
      req_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (exec_go && (req_put_r == ACT_GET)) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  // A capacity of zero acts as one; anything above the row length saturates.
  always_comb begin
    cap_nxt = cap_r;
    if (cfg_xfer) begin
      if (cfg_capacity_in_use == '0) begin
        cap_nxt = CNT_W'(1);
      end else if (32'(cfg_capacity_in_use) > 32'(ENTRIES)) begin
        cap_nxt = CNT_W'(ENTRIES);
      end else begin
        cap_nxt = CNT_W'(cfg_capacity_in_use);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      cap_r     <= CNT_W'(CAP_RST);
    end else begin
      req_vld_r <= req_vld_nxt;
      out_vld_r <= out_vld_nxt;
      cap_r     <= cap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_put_r <= in_action;
      req_key_r <= $unsigned(in_key);
      req_val_r <= $unsigned(in_value);
    end
    if (exec_go && (req_put_r == ACT_GET)) begin
      out_hit_r <= hit;
      out_val_r <= rd_val;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = $signed(out_val_r);

  // Keys are unique among valid entries, so at most one cell can match.
  a_one_match: assert property (@(posedge clk) disable iff (!rst_n)
    req_vld_r |-> $onehot0(match_vec))
    else $error("more than one cell matched the request key");

  // A fresh result can only come from an executed get.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !$past(out_vld_r && out_stall)) |->
      $past(exec_go && (req_put_r == ACT_GET)))
    else $error("result appeared without an executed get");

  // A capacity write leaves the row empty.
  a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_xfer |=> (vld_vec == '0))
    else $error("store not cleared after a capacity write");

  // Valid entries stay packed at the head of the row.
  a_packed: assert property (@(posedge clk) disable iff (!rst_n)
    ((vld_vec & (vld_vec + 1'b1)) == '0))
    else $error("valid entries are not contiguous from the head");

endmodule

// ===== tb/tb_lru_key_value_cache_core.sv =====
// Self-checking testbench for the LRU key-value cache core with its own LRU predictor.
module tb_lru_key_value_cache_core;
  import lkvc_pkg::*;

  localparam int SLOTS       = ENTRIES_DEF;
  localparam int CYCLE_LIMIT = 400000;
  // Puts give no result, so the tail still waits after the last answer before
  // touching the register.
  localparam int SETTLE      = 8;
  localparam int HOLD_LEN    = 60;
  localparam int PHASE_ITEMS = 110;

  // One request as it travels the input channel.
  typedef struct packed {
    logic             action;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } request_t;

  // One lookup answer as it travels the result channel.
  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] data;
  } lookup_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic                    in_action;
  logic signed [KEY_W-1:0] in_key;
  logic signed [VAL_W-1:0] in_value;
  logic                    out_valid;
  logic                    out_stall;
  logic                    out_hit;
  logic signed [VAL_W-1:0] out_read_value;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CAP_W-1:0]        cfg_capacity_in_use;

  lru_key_value_cache_core u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_key              (in_key),
    .in_value            (in_value),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_hit             (out_hit),
    .out_read_value      (out_read_value),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_capacity_in_use (cfg_capacity_in_use)
  );

  // Requests waiting to be offered, and lookup answers waiting to come back.
  request_t pending_req_q[$];
  lookup_t  lookup_q[$];

  // Shadow copy of the cache. Age 0 is the most recently used entry, and the
  // live entries always hold the ages 0 .. live_count-1 exactly once.
  logic [KEY_W-1:0] shadow_key  [SLOTS];
  logic [VAL_W-1:0] shadow_val  [SLOTS];
  logic             shadow_live [SLOTS];
  int unsigned      shadow_age  [SLOTS];
  int unsigned      live_count;
  logic [CAP_W-1:0] capacity_reg;

  int  error_count    = 0;
  int  cycle_count    = 0;
  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  int  hold_requests  = 0;
  int  hold_seen      = 0;
  int  hold_left      = 0;
  bit  in_fire        = 1'b0;
  request_t offer;
  lookup_t  want;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Runaway guard: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_lru_key_value_cache_core: errors");
      $finish;
    end
  end

  function automatic void log_error(string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR @%0d: %s", cycle_count, msg);
  endfunction

  // Zero and anything above the entry count are clamped, as the block does.
  function automatic int unsigned usable_capacity();
    if (capacity_reg == 0) return 1;
    if (capacity_reg > SLOTS) return SLOTS;
    return 32'(capacity_reg);
  endfunction

  function automatic void wipe_shadow();
    for (int i = 0; i < SLOTS; i++) begin
      shadow_key[i]  = '0;
      shadow_val[i]  = '0;
      shadow_live[i] = 1'b0;
      shadow_age[i]  = 0;
    end
    live_count = 0;
  endfunction

  // Make one entry the most recent; everything younger than it ages by one.
  function automatic void promote(int idx);
    int unsigned was;
    was = shadow_age[idx];
    for (int i = 0; i < SLOTS; i++)
      if (shadow_live[i] && shadow_age[i] < was) shadow_age[i]++;
    shadow_age[idx] = 0;
  endfunction

  function automatic void drop_oldest();
    if (live_count == 0) return;
    for (int i = 0; i < SLOTS; i++) begin
      if (shadow_live[i] && shadow_age[i] == live_count - 1) begin
        shadow_live[i] = 1'b0;
        shadow_age[i]  = 0;
        live_count--;
        return;
      end
    end
  endfunction

  // New keys go to the lowest free slot and every live entry ages by one.
  function automatic void insert_fresh(logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    int slot;
    slot = -1;
    for (int i = 0; i < SLOTS; i++)
      if (!shadow_live[i] && slot < 0) slot = i;
    if (slot < 0) return;
    for (int i = 0; i < SLOTS; i++)
      if (shadow_live[i]) shadow_age[i]++;
    shadow_key[slot]  = k;
    shadow_val[slot]  = v;
    shadow_live[slot] = 1'b1;
    shadow_age[slot]  = 0;
    live_count++;
  endfunction

  // Applies one accepted request to the shadow cache. A get queues the answer
  // the block owes; a put updates or inserts and owes nothing.
  function automatic void serve_request(request_t r);
    int      found;
    lookup_t ans;
    found = -1;
    for (int i = 0; i < SLOTS; i++)
      if (found < 0 && shadow_live[i] && shadow_key[i] == r.key) found = i;
    if (r.action == ACT_GET) begin
      if (found >= 0) begin
        ans.hit  = 1'b1;
        ans.data = shadow_val[found];
        promote(found);
      end else begin
        ans.hit  = 1'b0;
        ans.data = '0;
      end
      lookup_q.push_back(ans);
    end else if (found >= 0) begin
      shadow_val[found] = r.value;
      promote(found);
    end else begin
      if (live_count >= usable_capacity()) drop_oldest();
      insert_fresh(r.key, r.value);
    end
  endfunction

  // Driver: a new request is offered only once the previous one has made its
  // transfer, and a stalled request is held unchanged. Valid is decided by the
  // idle dice and the pending queue, never by the stall.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fire)) begin
      if (pending_req_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        offer     = pending_req_q.pop_front();
        in_valid  <= 1'b1;
        in_action <= offer.action;
        in_key    <= offer.key;
        in_value  <= offer.value;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result-side back-pressure. A requested hold keeps the stall high for a
  // long stretch so the block fills up and pushes back on its input.
  always @(negedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen <= hold_requests;
      hold_left <= HOLD_LEN;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor: checks each result transfer against the oldest owed answer, then
  // feeds each input transfer through the predictor.
  always @(posedge clk) begin
    if (rst_n) begin
      in_fire <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (lookup_q.size() == 0) begin
          log_error($sformatf("unexpected result hit=%0b value=%h", out_hit, out_read_value));
        end else begin
          want = lookup_q.pop_front();
          if (out_hit !== want.hit)
            log_error($sformatf("hit: expected %0b, got %0b", want.hit, out_hit));
          if (out_read_value !== want.data)
            log_error($sformatf("read_value: expected %h, got %h", want.data,
                                out_read_value));
        end
      end
      if (in_valid && !in_stall) serve_request('{in_action, in_key, in_value});
    end
  end

  function automatic void push_req(logic act, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    pending_req_q.push_back('{act, k, v});
  endfunction

  // Waits until every request is gone and every answer is back, then lets the
  // block finish any put still in flight.
  task automatic wait_quiet();
    while (pending_req_q.size() > 0 || in_valid || lookup_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Register writes happen only while the block is quiet; the shadow cache is
  // cleared at the edge where the transfer takes place.
  task automatic write_capacity(logic [CAP_W-1:0] cap);
    @(negedge clk);
    cfg_capacity_in_use <= cap;
    cfg_valid           <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    capacity_reg = cap;
    wipe_shadow();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [KEY_W-1:0] corner_word();
    case ($urandom_range(3))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // Random traffic over a key pool a little larger than the capacity, so hits,
  // updates and evictions all stay frequent. A few keys fall outside the pool.
  task automatic random_phase(logic [CAP_W-1:0] cap, int mode, bit hold);
    logic [KEY_W-1:0] pool[$];
    logic [KEY_W-1:0] k;
    int               pick;
    write_capacity(cap);
    pool.delete();
    for (int i = 0; i < usable_capacity() + $urandom_range(1, 4); i++)
      pool.push_back($urandom);
    if ($urandom_range(1)) pool[0] = corner_word();
    case (mode)
      0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1:       begin send_idle_pct = 84; recv_stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct = 84; end
      default: begin send_idle_pct = 7;  recv_stall_pct = 7;  end
    endcase
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      pick = $urandom_range(99);
      if (pick < 88)      k = pool[$urandom_range(pool.size() - 1)];
      else if (pick < 95) k = $urandom;
      else                k = corner_word();
      push_req(($urandom_range(99) < 45) ? ACT_PUT : ACT_GET, k, $urandom);
    end
    if (hold) hold_requests++;
    wait_quiet();
  endtask

  initial begin
    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_action           = ACT_GET;
    in_key              = '0;
    in_value            = '0;
    out_stall           = 1'b0;
    cfg_valid           = 1'b0;
    cfg_capacity_in_use = '0;
    capacity_reg        = CAP_W'(CAP_RESET);
    wipe_shadow();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part at the reset capacity: a lookup in the empty store, the
    // extreme keys and values, hits on each, an update of a present key and a
    // miss whose ignored value field is all ones.
    push_req(ACT_GET, 32'h0000_0000, 32'h0000_0000);
    push_req(ACT_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    push_req(ACT_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    push_req(ACT_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    push_req(ACT_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    push_req(ACT_GET, 32'h8000_0000, 32'h0000_0000);
    push_req(ACT_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    push_req(ACT_GET, 32'h0000_0000, 32'h0000_0000);
    push_req(ACT_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    push_req(ACT_PUT, 32'h8000_0000, 32'h1234_5678);
    push_req(ACT_GET, 32'h8000_0000, 32'h0000_0000);
    push_req(ACT_GET, 32'h0000_0001, 32'hFFFF_FFFF);
    wait_quiet();

    // A capacity of zero behaves as one: the second put evicts the first.
    write_capacity(0);
    push_req(ACT_PUT, 32'd5, 32'd50);
    push_req(ACT_PUT, 32'd6, 32'd60);
    push_req(ACT_GET, 32'd5, 32'd0);
    push_req(ACT_GET, 32'd6, 32'd0);
    wait_quiet();

    // With two entries a hit refreshes key 1, so the insert of key 3 evicts 2.
    write_capacity(2);
    push_req(ACT_PUT, 32'd1, 32'd10);
    push_req(ACT_PUT, 32'd2, 32'd20);
    push_req(ACT_GET, 32'd1, 32'd0);
    push_req(ACT_PUT, 32'd3, 32'd30);
    push_req(ACT_GET, 32'd2, 32'd0);
    push_req(ACT_GET, 32'd1, 32'd0);
    push_req(ACT_GET, 32'd3, 32'd0);
    wait_quiet();

    // Random phases walk the capacity through its extremes, the clamped
    // values and a few in between, cycling through the idle patterns. The
    // first one also carries the long result-side hold.
    random_phase(16, 0, 1'b1);
    random_phase(31, 1, 1'b0);
    random_phase(1,  2, 1'b0);
    random_phase(17, 3, 1'b0);
    random_phase(3,  0, 1'b0);
    random_phase(0,  1, 1'b0);
    random_phase(8,  2, 1'b0);
    random_phase(2,  3, 1'b0);
    random_phase(CAP_W'($urandom_range(4, 15)), 0, 1'b0);
    random_phase(5,  1, 1'b0);
    random_phase(16, 2, 1'b0);
    random_phase(CAP_W'($urandom_range(1, 31)), 3, 1'b0);

    if (lookup_q.size() != 0) log_error("answers still owed at the end of the run");
    if (error_count == 0) begin
      $display("tb_lru_key_value_cache_core: clean");
    end else begin
      $display("tb_lru_key_value_cache_core: errors");
    end
    $finish;
  end

endmodule
